// ===== design/etpf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, link-count codes and controller/datapath interface types
// for the topology parent finder. Depends on nothing.
package etpf_pkg;

    localparam int MAX_SLAVES_DEF = 256;

    localparam int LS_W      = 16;   // link status word
    localparam int POS_W     = 9;    // reported positions
    localparam int LT_W      = 3;    // link total
    localparam int NUM_PORTS = 4;
    localparam int PORT_LSB  = 8;    // port 0 field starts at this bit

    localparam logic [1:0] PORT_LINKED = 2'b10;

    // Link counts that move the balance during the backward walk.
    localparam logic [LT_W-1:0] LC_END   = 3'd1;
    localparam logic [LT_W-1:0] LC_SPLIT = 3'd3;
    localparam logic [LT_W-1:0] LC_CROSS = 3'd4;

    localparam logic [POS_W-1:0] PARENT_MASTER = 9'h1FF;

    typedef struct packed {
        logic accept;    // take the input request, store its link count
        logic walk;      // evaluate one table entry
        logic load_out;  // move the finished result into the output register
    } t_cmd;

    typedef struct packed {
        logic skip;      // first slave or table full: no walk needed
        logic hit;       // current entry ends the walk
    } t_sts;

endpackage

// ===== design/etpf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module etpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/etpf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences accept, backward walk and result hand-off.
// Depends on etpf_pkg.
module etpf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  etpf_pkg::t_sts i_sts,
    output etpf_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       out_free;

    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.skip ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ovalid = o_cmd.load_out || (r_ovalid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule

// ===== design/etpf_dp.sv =====
`timescale 1ns / 1ps
// Datapath: port decode, scan counter, link-count table, balance walk and
// output register. Depends on etpf_pkg and etpf_ram.
module etpf_dp #(
    parameter int MAX_SLAVES = etpf_pkg::MAX_SLAVES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  etpf_pkg::t_cmd                     i_cmd,
    output etpf_pkg::t_sts                     o_sts,
    input  logic [etpf_pkg::LS_W-1:0]          i_link_status,
    input  logic                              i_new_scan,
    output logic [etpf_pkg::POS_W-1:0]         o_slave_position,
    output logic [etpf_pkg::LT_W-1:0]          o_link_total,
    output logic [etpf_pkg::NUM_PORTS-1:0]     o_port_mask,
    output logic signed [etpf_pkg::POS_W-1:0]  o_parent_position,
    output logic                              o_overflow
);

    localparam int CW = $clog2(MAX_SLAVES + 1);   // count, holds MAX_SLAVES
    localparam int AW = $clog2(MAX_SLAVES);       // table address
    localparam int BW = CW + 1;                   // balance, two's complement

    logic [CW-1:0]                      r_seen;
    logic [CW-1:0]                      r_pos;
    logic [etpf_pkg::LT_W-1:0]          r_count;
    logic [etpf_pkg::NUM_PORTS-1:0]     r_mask;
    logic                               r_ovf;
    logic [AW-1:0]                      r_idx, n_idx;
    logic [BW-1:0]                      r_bal, bal_next;
    logic [etpf_pkg::POS_W-1:0]         r_parent;

    logic [CW-1:0]                      cur_pos, pos_m1;
    logic                               ovf;
    logic [etpf_pkg::LT_W-1:0]          dec_count;
    logic [etpf_pkg::NUM_PORTS-1:0]     dec_mask;
    logic [etpf_pkg::LT_W-1:0]          lc;

    always_comb begin
        dec_count = '0;
        dec_mask  = '0;
        for (int p = 0; p < etpf_pkg::NUM_PORTS; p++) begin
            if (i_link_status[etpf_pkg::PORT_LSB + 2*p +: 2] == etpf_pkg::PORT_LINKED) begin
                dec_count   = dec_count + 3'd1;
                dec_mask[p] = 1'b1;
            end
        end
    end

    assign cur_pos = i_new_scan ? '0 : r_seen;
    assign pos_m1  = cur_pos - CW'(1);
    assign ovf     = (cur_pos == CW'(MAX_SLAVES));

    // The read address is the next walk index, so data for an entry is ready
    // in the same cycle as its registered index: one entry per cycle.
    always_comb begin
        if (i_cmd.accept) begin
            n_idx = pos_m1[AW-1:0];
        end else if (i_cmd.walk) begin
            n_idx = r_idx - AW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    etpf_ram #(
        .WIDTH (etpf_pkg::LT_W),
        .DEPTH (MAX_SLAVES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && !ovf),
        .i_waddr (cur_pos[AW-1:0]),
        .i_wdata (dec_count),
        .i_raddr (n_idx),
        .o_rdata (lc)
    );

    always_comb begin
        case (lc)
            etpf_pkg::LC_END:   bal_next = r_bal - BW'(1);
            etpf_pkg::LC_SPLIT: bal_next = r_bal + BW'(1);
            etpf_pkg::LC_CROSS: bal_next = r_bal + BW'(2);
            default:            bal_next = r_bal;
        endcase
    end

    assign o_sts.skip = ovf || (cur_pos == '0);
    assign o_sts.hit  = (!bal_next[BW-1] && (lc > etpf_pkg::LT_W'(1))) || (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_cmd.accept) begin
            r_seen <= ovf ? cur_pos : cur_pos + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.accept) begin
            r_pos    <= cur_pos;
            r_count  <= dec_count;
            r_mask   <= dec_mask;
            r_ovf    <= ovf;
            r_bal    <= '0;
            r_parent <= etpf_pkg::PARENT_MASTER;
        end
        if (i_cmd.walk) begin
            r_bal <= bal_next;
            if (o_sts.hit) begin
                r_parent <= etpf_pkg::POS_W'(r_idx);
            end
        end
        if (i_cmd.load_out) begin
            o_slave_position  <= etpf_pkg::POS_W'(r_pos);
            o_link_total      <= r_count;
            o_port_mask       <= r_mask;
            o_parent_position <= r_parent;
            o_overflow        <= r_ovf;
        end
    end

endmodule

// ===== design/ethercat_topology_parent_finder.sv =====
`timescale 1ns / 1ps
// Top level of the topology parent finder: controller plus datapath.
// Depends on etpf_pkg, etpf_ctrl, etpf_dp (and etpf_ram below it).
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | i_valid / o_stall  | i_link_status, i_new_scan
//  result   | out       | o_valid / i_stall  | o_slave_position, o_link_total,
//           |           |                    | o_port_mask, o_parent_position,
//           |           |                    | o_overflow
//
// A request is accepted only in idle; unless it is the first slave or the table is full,
// the backward walk then visits earlier table entries (at most the slave's position) before
// the result is loaded into the output register. The next request waits until that is done.
// The walk reads one entry per cycle from the single read port of the link-count RAM.
// Reset clears the scan count and the handshake state; the table is not cleared.
// A result held in the output register by i_stall stalls the next finished request.
module ethercat_topology_parent_finder #(
    parameter int MAX_SLAVES = etpf_pkg::MAX_SLAVES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [etpf_pkg::LS_W-1:0]          i_link_status,
    input  logic                              i_new_scan,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [etpf_pkg::POS_W-1:0]         o_slave_position,
    output logic [etpf_pkg::LT_W-1:0]          o_link_total,
    output logic [etpf_pkg::NUM_PORTS-1:0]     o_port_mask,
    output logic signed [etpf_pkg::POS_W-1:0]  o_parent_position,
    output logic                              o_overflow
);

    etpf_pkg::t_cmd cmd;
    etpf_pkg::t_sts sts;

    etpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    etpf_dp #(
        .MAX_SLAVES (MAX_SLAVES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_link_status     (i_link_status),
        .i_new_scan        (i_new_scan),
        .o_slave_position  (o_slave_position),
        .o_link_total      (o_link_total),
        .o_port_mask       (o_port_mask),
        .o_parent_position (o_parent_position),
        .o_overflow        (o_overflow)
    );

endmodule

// ===== design/etpf_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the topology parent finder and its bind statement.
// Depends on etpf_pkg and ethercat_topology_parent_finder.
module etpf_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic [etpf_pkg::LS_W-1:0]          i_link_status,
    input  logic                              i_new_scan,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [etpf_pkg::POS_W-1:0]         o_slave_position,
    input  logic [etpf_pkg::LT_W-1:0]          o_link_total,
    input  logic [etpf_pkg::NUM_PORTS-1:0]     o_port_mask,
    input  logic signed [etpf_pkg::POS_W-1:0]  o_parent_position,
    input  logic                              o_overflow
);

    // The input is always stalled in the cycle after a request is accepted.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a request was accepted");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_link_status)
            && $stable(i_new_scan)))
        else $error("stalled request changed or dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_parent_position)
            && $stable(o_slave_position) && $stable(o_overflow)))
        else $error("stalled result changed or dropped");

    a_ovf_master: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_parent_position == etpf_pkg::PARENT_MASTER))
        else $error("overflow result has a parent other than the master");

    a_total_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_link_total == etpf_pkg::LT_W'($countones(o_port_mask))))
        else $error("link total disagrees with port mask");

endmodule

bind ethercat_topology_parent_finder etpf_chk u_etpf_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .i_link_status     (i_link_status),
    .i_new_scan        (i_new_scan),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_slave_position  (o_slave_position),
    .o_link_total      (o_link_total),
    .o_port_mask       (o_port_mask),
    .o_parent_position (o_parent_position),
    .o_overflow        (o_overflow)
);
